### src/smf_pkg.sv
package smf_pkg;

    // Widths of the stream fields and of the configuration register
    localparam int DATA_W = 32;
    localparam int CFG_W  = 4;

    // Operation broadcast to every cell in the row
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_DROP,
        OP_INSERT
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRIM,
        ST_EMIT,
        ST_FLUSH
    } smf_state_t;

endpackage

### src/sliding_median_filter_rows_unit.sv
// Running median over rows of unsigned Q16.16 samples.
// Input word on s_axis: tdata holds the sample, tlast marks the last sample of a row.
// Output word on m_axis: tdata holds the median, tlast marks the last result of a row.
// cfg_we/cfg_wdata load half_width (kernel 2*half_width+1); write it only while idle.
// Result p of a row is the median of samples p-h..p+h, clipped at the row ends; an
// even count gives the mean of the two middle values, rounded down.
// The window lives in a row of 2*MAX_HALF+1 cells kept in sorted order, each tagged
// with its arrival age; the row does one drop or one insert per cycle.
// Steps: a sample is accepted, the oldest samples are dropped until at most 2h remain,
// the sample is inserted, and a result is emitted once h later samples are in.
// The row_last sample then steps through its pending results (trim, emit). Each
// result goes to m_axis through the output register.
// A single output register decouples the sides; while it is stalled the block
// holds at the next emit and s_axis_tready stays low until the item is done.
// Reset clears the window, the pending count and half_width (to zero); no clearing
// pass is needed.
module sliding_median_filter_rows_unit
    import smf_pkg::*;
#(
    parameter int MAX_HALF     = 15,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] sample
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] median_value
    output logic              m_axis_tlast,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int DEPTH = 2 * MAX_HALF + 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int AGE_W = $clog2(DEPTH);

    cell_op_t                cell_op;
    logic [CW-1:0]           count;
    logic [SAMPLE_WIDTH-1:0] new_val;
    logic [AGE_W-1:0]        new_age;
    logic [SAMPLE_WIDTH-1:0] mid_lo, mid_hi;
    logic [CW-1:0]           half_count;

    logic [SAMPLE_WIDTH-1:0] cell_val  [DEPTH];
    logic [AGE_W-1:0]        cell_age  [DEPTH];
    logic [DEPTH-1:0]        cell_lt;
    logic [DEPTH-1:0]        cell_drop;
    logic [DEPTH-1:0]        cell_valid;
    logic [DEPTH-1:0]        hi_sel;
    logic [DEPTH-1:0]        lo_sel;

    assign half_count = count >> 1;

    smf_ctrl #(
        .MAX_HALF     (MAX_HALF),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mid_lo        (mid_lo),
        .mid_hi        (mid_hi),
        .cell_op       (cell_op),
        .count         (count),
        .new_val       (new_val),
        .new_age       (new_age)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [SAMPLE_WIDTH-1:0] left_val, right_val;
        logic [AGE_W-1:0]        left_age, right_age;
        logic                    left_lt, drop_in;

        assign cell_valid[i] = CW'(i) < count;
        assign hi_sel[i]     = CW'(i) == half_count;
        // odd count: both middle picks are the same cell
        assign lo_sel[i]     = count[0] ? hi_sel[i] : (CW'(i + 1) == half_count);

        if (i == 0) begin : g_first
            assign left_val = '0;
            assign left_age = '0;
            assign left_lt  = 1'b1;
            assign drop_in  = 1'b0;
        end else begin : g_inner
            assign left_val = cell_val[i-1];
            assign left_age = cell_age[i-1];
            assign left_lt  = cell_lt[i-1];
            assign drop_in  = cell_drop[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_val = '0;
            assign right_age = '0;
        end else begin : g_mid
            assign right_val = cell_val[i+1];
            assign right_age = cell_age[i+1];
        end

        smf_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_W        (AGE_W)
        ) u_cell (
            .aclk       (aclk),
            .op         (cell_op),
            .cell_valid (cell_valid[i]),
            .new_val    (new_val),
            .new_age    (new_age),
            .left_val   (left_val),
            .left_age   (left_age),
            .left_lt    (left_lt),
            .right_val  (right_val),
            .right_age  (right_age),
            .drop_in    (drop_in),
            .val        (cell_val[i]),
            .age        (cell_age[i]),
            .lt_out     (cell_lt[i]),
            .drop_out   (cell_drop[i])
        );
    end

    // one-hot pick of the two middle cells
    always_comb begin
        mid_lo = '0;
        mid_hi = '0;
        for (int i = 0; i < DEPTH; i++) begin
            mid_lo = mid_lo | (cell_val[i] & {SAMPLE_WIDTH{lo_sel[i]}});
            mid_hi = mid_hi | (cell_val[i] & {SAMPLE_WIDTH{hi_sel[i]}});
        end
    end

endmodule

### src/smf_cell.sv
module smf_cell
    import smf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32,
    parameter int AGE_W        = 5
) (
    input  logic                    aclk,
    input  cell_op_t                op,
    input  logic                    cell_valid,
    input  logic [SAMPLE_WIDTH-1:0] new_val,
    input  logic [AGE_W-1:0]        new_age,
    input  logic [SAMPLE_WIDTH-1:0] left_val,
    input  logic [AGE_W-1:0]        left_age,
    input  logic                    left_lt,
    input  logic [SAMPLE_WIDTH-1:0] right_val,
    input  logic [AGE_W-1:0]        right_age,
    input  logic                    drop_in,
    output logic [SAMPLE_WIDTH-1:0] val,
    output logic [AGE_W-1:0]        age,
    output logic                    lt_out,
    output logic                    drop_out
);

    logic [SAMPLE_WIDTH-1:0] val_reg, val_next;
    logic [AGE_W-1:0]        age_reg, age_next;

    assign val = val_reg;
    assign age = age_reg;

    // held value sorts below the incoming sample
    assign lt_out   = cell_valid && (val_reg < new_val);
    // the oldest entry sits here or to the left: close the gap from the right
    assign drop_out = drop_in || (cell_valid && (age_reg == '0));

    always_comb begin
        val_next = val_reg;
        age_next = age_reg;
        case (op)
            OP_DROP: begin
                if (drop_out) begin
                    val_next = right_val;
                    age_next = right_age - 1'b1;
                end else begin
                    age_next = age_reg - 1'b1;
                end
            end
            OP_INSERT: begin
                if (!lt_out) begin
                    if (left_lt) begin
                        val_next = new_val;
                        age_next = new_age;
                    end else begin
                        val_next = left_val;
                        age_next = left_age;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        age_reg <= age_next;
    end

endmodule

### src/smf_ctrl.sv
module smf_ctrl
    import smf_pkg::*;
#(
    parameter int MAX_HALF     = 15,
    parameter int SAMPLE_WIDTH = 32,
    parameter int DEPTH        = 2 * MAX_HALF + 1,
    parameter int CW           = $clog2(DEPTH + 1),
    parameter int AGE_W        = $clog2(DEPTH)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [DATA_W-1:0]       s_axis_tdata,
    input  logic                    s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [DATA_W-1:0]       m_axis_tdata,
    output logic                    m_axis_tlast,
    input  logic                    cfg_we,
    input  logic [CFG_W-1:0]        cfg_wdata,
    input  logic [SAMPLE_WIDTH-1:0] mid_lo,
    input  logic [SAMPLE_WIDTH-1:0] mid_hi,
    output cell_op_t                cell_op,
    output logic [CW-1:0]           count,
    output logic [SAMPLE_WIDTH-1:0] new_val,
    output logic [AGE_W-1:0]        new_age
);

    smf_state_t state_reg, state_next;

    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           pend_reg, pend_next;
    logic [CFG_W-1:0]        half_width_reg;
    logic [SAMPLE_WIDTH-1:0] sample_reg;
    logic                    last_reg;
    logic                    m_valid_reg;
    logic [SAMPLE_WIDTH-1:0] m_data_reg;
    logic                    m_last_reg;

    logic [CW-1:0]           h_eff;
    logic                    trim_need;
    logic                    emit_need;
    logic                    flush_drop;
    logic                    out_free;
    logic                    emit;
    logic                    emit_last;
    logic [SAMPLE_WIDTH:0]   mid_sum;
    logic [SAMPLE_WIDTH-1:0] median;

    assign h_eff = (int'(half_width_reg) > MAX_HALF) ? CW'(MAX_HALF) : CW'(half_width_reg);

    // window must be at most 2h before a new sample goes in
    assign trim_need  = {1'b0, count_reg} > {h_eff, 1'b0};
    assign emit_need  = pend_reg > h_eff;
    // position with d = pend-1 later samples keeps at most h+d+1 entries
    assign flush_drop = (CW + 1)'(count_reg) > ((CW + 1)'(h_eff) + (CW + 1)'(pend_reg));
    assign out_free   = !m_valid_reg || m_axis_tready;

    // odd count selects the same cell twice, so the halved sum is exact
    assign mid_sum = {1'b0, mid_lo} + {1'b0, mid_hi};
    assign median  = mid_sum[SAMPLE_WIDTH:1];

    assign count         = count_reg;
    assign new_val       = sample_reg;
    assign new_age       = count_reg[AGE_W-1:0];
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = DATA_W'(m_data_reg);
    assign m_axis_tlast  = m_last_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM: begin
                if (!trim_need) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // kernel of one: the row closes with this result
                if (!emit_need || out_free) begin
                    state_next = (last_reg && (h_eff != '0)) ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (pend_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (!flush_drop && out_free && (pend_reg == CW'(1))) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        cell_op       = OP_HOLD;
        emit          = 1'b0;
        emit_last     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_TRIM: begin
                cell_op = trim_need ? OP_DROP : OP_INSERT;
            end
            ST_EMIT: begin
                emit      = emit_need && out_free;
                emit_last = last_reg && (h_eff == '0);
            end
            ST_FLUSH: begin
                if (pend_reg != '0) begin
                    if (flush_drop) begin
                        cell_op = OP_DROP;
                    end else begin
                        emit      = out_free;
                        emit_last = (pend_reg == CW'(1));
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        pend_next  = pend_reg;
        case (cell_op)
            OP_DROP: begin
                count_next = count_reg - 1'b1;
            end
            OP_INSERT: begin
                count_next = count_reg + 1'b1;
                pend_next  = pend_reg + 1'b1;
            end
            default: begin
            end
        endcase
        if (state_reg == ST_EMIT && emit) begin
            pend_next = h_eff;
            if (emit_last) begin
                count_next = '0;
            end
        end
        if (state_reg == ST_FLUSH) begin
            if (pend_reg == '0) begin
                count_next = '0;
            end else if (emit) begin
                pend_next = pend_reg - 1'b1;
                if (pend_reg == CW'(1)) begin
                    count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_reg       <= '0;
            half_width_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            if (cfg_we) begin
                half_width_reg <= cfg_wdata;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            sample_reg <= s_axis_tdata[SAMPLE_WIDTH-1:0];
            last_reg   <= s_axis_tlast;
        end
        if (emit) begin
            m_data_reg <= median;
            m_last_reg <= emit_last;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= DEPTH)
        else $error("window count beyond cell row");

    a_pend_has_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) && (pend_reg != '0) |-> (count_reg != '0))
        else $error("pending positions with an empty window");

    a_drop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_op == OP_DROP) |-> (count_reg != '0))
        else $error("drop from an empty window");

    a_row_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && emit_last |=> (state_reg == ST_IDLE) && (count_reg == '0) && (pend_reg == '0))
        else $error("row state not cleared after last result");
`endif

endmodule

### tb/smf_median_checker.sv
module smf_median_checker
    import smf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,
    input  logic              s_axis_tlast,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [DATA_W-1:0] m_axis_tdata,
    input  logic              m_axis_tlast,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    output int                fail_count,
    output int                owed_count,
    output int                samples_seen,
    output int                medians_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_HALF = 15;
    localparam int WIN      = 2 * MAX_HALF + 1;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              row_end;
    } median_t;

    median_t           median_q[$];
    logic [DATA_W-1:0] sorted_win[WIN];
    logic [DATA_W-1:0] arrival_win[WIN];
    int                win_cnt;
    int                lag;
    logic [CFG_W-1:0]  half_q;

    initial begin
        fail_count   = 0;
        owed_count   = 0;
        samples_seen = 0;
        medians_seen = 0;
        win_cnt      = 0;
        lag          = 0;
        half_q       = '0;
    end

    function automatic void drop_oldest_sample();
        logic [DATA_W-1:0] v;
        int                k;
        int                i;
        if (win_cnt == 0) return;
        v = arrival_win[0];
        for (i = 0; i < win_cnt - 1; i++) arrival_win[i] = arrival_win[i + 1];
        k = 0;
        while (k < win_cnt && sorted_win[k] < v) k++;
        if (k >= win_cnt) k = win_cnt - 1;
        for (i = k; i < win_cnt - 1; i++) sorted_win[i] = sorted_win[i + 1];
        win_cnt--;
    endfunction

    function automatic void insert_sample(logic [DATA_W-1:0] v);
        int k;
        int i;
        if (win_cnt >= WIN) return;
        k = 0;
        while (k < win_cnt && sorted_win[k] < v) k++;
        for (i = win_cnt; i > k; i--) sorted_win[i] = sorted_win[i - 1];
        sorted_win[k]        = v;
        arrival_win[win_cnt] = v;
        win_cnt++;
    endfunction

    // even count: mean of the two middle values, summed at 33 bits
    function automatic logic [DATA_W-1:0] window_median();
        logic [DATA_W:0] sum;
        if (win_cnt == 0) return '0;
        if (win_cnt % 2 == 1) return sorted_win[win_cnt / 2];
        sum = {1'b0, sorted_win[win_cnt / 2 - 1]} + {1'b0, sorted_win[win_cnt / 2]};
        return sum[DATA_W:1];
    endfunction

    function automatic void push_median(logic [DATA_W-1:0] v);
        median_t m;
        m.value   = v;
        m.row_end = 1'b0;
        median_q.push_back(m);
    endfunction

    function automatic void predict_medians(logic [DATA_W-1:0] v, logic last);
        int h;
        int pend;
        int n;
        h = half_q;
        n = 0;
        while (win_cnt > 2 * h) drop_oldest_sample();
        insert_sample(v);
        pend = lag + 1;
        if (pend > h) begin
            push_median(window_median());
            n++;
            pend = h;
        end
        if (last) begin
            // flush: each pending position sees a window clipped at the row end
            while (pend > 0) begin
                while (win_cnt > h + pend) drop_oldest_sample();
                push_median(window_median());
                n++;
                pend--;
            end
            if (n > 0) median_q[median_q.size() - 1].row_end = 1'b1;
            win_cnt = 0;
        end
        lag = pend;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            median_q.delete();
            win_cnt = 0;
            lag     = 0;
            half_q  = '0;
        end else begin
            if (cfg_we) half_q = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_medians(s_axis_tdata, s_axis_tlast);
                samples_seen++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                medians_seen++;
                if (median_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("[%0t] unexpected result word: value %h end %b",
                                 $realtime, m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end else if (m_axis_tdata !== median_q[0].value ||
                             m_axis_tlast !== median_q[0].row_end) begin
                    if (fail_count < 10)
                        $display("[%0t] result %0d: expected value %h end %b, got value %h end %b",
                                 $realtime, medians_seen, median_q[0].value,
                                 median_q[0].row_end, m_axis_tdata, m_axis_tlast);
                    fail_count++;
                    void'(median_q.pop_front());
                end else begin
                    void'(median_q.pop_front());
                end
            end
        end
        owed_count = median_q.size();
    end

endmodule

### tb/tb_sliding_median_filter_rows_unit.sv
module tb_sliding_median_filter_rows_unit
    import smf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT        = 200000;
    localparam int SETTLE       = 40;
    localparam int RANDOM_ITEMS = 130;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;
    logic              cfg_we        = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata     = '0;

    int fail_count;
    int owed_count;
    int samples_seen;
    int medians_seen;
    int cycles      = 0;
    int hold_len    = 0;
    int cfg_writes  = 0;
    int rows_sent   = 0;
    logic calm      = 1'b0;

    sliding_median_filter_rows_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    smf_median_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .owed_count    (owed_count),
        .samples_seen  (samples_seen),
        .medians_seen  (medians_seen)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycles, owed_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        int stall_len;
        forever begin
            @(negedge aclk);
            if (hold_len > 0) begin
                stall_len = hold_len;
                hold_len  = 0;
                m_axis_tready <= 1'b0;
                repeat (stall_len) @(negedge aclk);
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 23);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the handshake
    task automatic send_word(input logic [DATA_W-1:0] d, input logic l);
        while (!calm && $urandom_range(99) < 23) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= l;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return DATA_W'($urandom_range(7));
            5:       return {16'(($urandom_range(3))), 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_row(input int len, input logic close_row);
        int i;
        for (i = 0; i < len; i++)
            send_word(pick_sample(), close_row && (i == len - 1));
        if (close_row) rows_sent++;
    endtask

    // block idle: no result owed, then enough cycles for a sample that owes none
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (owed_count != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_half(input int h);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(h);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        int phase;
        int h;
        int rows;
        int r;
        int len;
        int start_count;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // kernel of one after reset: every word returned as is
        send_word('0, 1'b0);
        send_word('1, 1'b1);
        send_word(32'hAAAA_5555, 1'b1);

        // widest kernel, row far shorter than it; every result is the median of all three samples
        write_half(15);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b0);
        send_word(32'h0000_0001, 1'b1);

        write_half(2);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'h0000_0007, 1'b0);
        send_word(32'h0000_0007, 1'b0);
        send_word(32'h0000_0007, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0001_0000, 1'b1);

        // kernel narrowed mid-row: surplus samples and positions are dropped
        write_half(3);
        send_word(32'h0000_0010, 1'b0);
        send_word(32'h0000_0030, 1'b0);
        send_word(32'h0000_0020, 1'b0);
        send_word(32'h0000_0050, 1'b0);
        send_word(32'h0000_0040, 1'b0);
        write_half(1);
        send_word(32'h0000_0060, 1'b0);
        send_word(32'h0000_0005, 1'b0);
        send_word(32'h0000_0070, 1'b1);

        start_count = samples_seen;
        phase = 0;
        while (samples_seen - start_count < RANDOM_ITEMS) begin
            phase++;
            h = (phase == 1) ? 15 : (phase == 2) ? 0 : $urandom_range(15);
            write_half(h);
            calm = (phase == 1);
            // kernel of one under a long hold-off: every word owes a result
            if (phase == 2) begin
                hold_len = 300;
                send_row(12, 1'b0);
            end
            rows = $urandom_range(1, 3);
            for (r = 0; r < rows; r++) begin
                len = ($urandom_range(5) == 0) ? $urandom_range(1, 40)
                                                : $urandom_range(1, 2 * h + 3);
                send_row(len, 1'b1);
            end
            // sometimes leave a row open so the next setting lands mid-row
            if ($urandom_range(3) == 0) send_row($urandom_range(1, 4), 1'b0);
        end
        calm = 1'b0;
        send_row(3, 1'b1);

        wait_quiet();
        $display("run covered %0d samples in %0d closed rows, %0d medians checked,",
                 samples_seen, rows_sent, medians_seen);
        $display("%0d half_width writes, one 300-cycle result hold-off", cfg_writes);
        if (fail_count == 0 && owed_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results owed", fail_count, owed_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
src/smf_pkg.sv
src/smf_cell.sv
src/smf_ctrl.sv
src/sliding_median_filter_rows_unit.sv
tb/smf_median_checker.sv
tb/tb_sliding_median_filter_rows_unit.sv
